FILE: sv/gic_pkg.sv
// Shared types, constants and configuration layout for the gamepad input conditioner.
package gic_pkg;

    // Field widths fixed by the controller interface.
    localparam int BTN_W       = 18;
    localparam int SAMPLE_W    = 12;
    localparam int AXIS_W      = 8;
    localparam int AXES        = 4;
    localparam int DEV_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int COUNT_W     = 3;

    // Default number of controller slots.
    localparam int MAX_DEVICES_DEF = 4;

    // Stick center value.
    localparam logic [AXIS_W-1:0] CENTER = 8'd128;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_INVERT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE      = 3'd5;

    typedef logic [AXIS_W-1:0]   t_axis;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [BTN_W-1:0]    t_buttons;

    // Configuration shared by all controllers.
    typedef struct packed {
        logic [COUNT_W-1:0] device_count;
        logic               press_level;
        t_buttons           button_enable;
        logic [AXES-1:0]    analog_enable;
        logic [AXES-1:0]    axis_invert;
        t_axis              deadzone;
    } t_cfg;

endpackage

FILE: sv/gic_button_debounce.sv
// Per-controller two-sample button debounce with raw and held button tables.
module gic_button_debounce #(
    parameter int MAX_DEVICES = gic_pkg::MAX_DEVICES_DEF,
    parameter int SLOT_W      = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gic_pkg::t_cfg         i_cfg,
    input  logic                  i_update,
    input  logic [SLOT_W-1:0]     i_slot,
    input  gic_pkg::t_buttons     i_levels,
    output gic_pkg::t_buttons     o_held
);

    gic_pkg::t_buttons r_last [MAX_DEVICES];
    gic_pkg::t_buttons r_held [MAX_DEVICES];
    gic_pkg::t_buttons w_pressed;

    // Polarity flip and unwired-button mask, then accept only a repeated word.
    always_comb begin
        w_pressed = i_cfg.press_level ? i_levels : ~i_levels;
        w_pressed = w_pressed & i_cfg.button_enable;
        o_held    = (w_pressed == r_last[i_slot]) ? w_pressed : r_held[i_slot];
    end

    // Table update on each poll of a registered controller.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DEVICES; d++) begin
                r_last[d] <= '0;
                r_held[d] <= '0;
            end
        end else if (i_update) begin
            r_last[i_slot] <= w_pressed;
            r_held[i_slot] <= o_held;
        end
    end

endmodule

FILE: sv/gic_axis_hold.sv
// Per-controller stick axis conditioning with held axis table.
module gic_axis_hold #(
    parameter int MAX_DEVICES = gic_pkg::MAX_DEVICES_DEF,
    parameter int SLOT_W      = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gic_pkg::t_cfg         i_cfg,
    input  logic                  i_update,
    input  logic [SLOT_W-1:0]     i_slot,
    input  gic_pkg::t_sample      i_samples [gic_pkg::AXES],
    output gic_pkg::t_axis        o_axes    [gic_pkg::AXES]
);

    gic_pkg::t_axis r_held [MAX_DEVICES][gic_pkg::AXES];
    gic_pkg::t_axis w_val  [gic_pkg::AXES];
    gic_pkg::t_axis w_dist [gic_pkg::AXES];

    // Keep the top bits, optionally invert, snap to center inside the deadzone; disabled axes show the held value.
    always_comb begin
        for (int a = 0; a < gic_pkg::AXES; a++) begin
            w_val[a] = i_samples[a][gic_pkg::SAMPLE_W-1 -: gic_pkg::AXIS_W];
            if (i_cfg.axis_invert[a]) begin
                w_val[a] = ~w_val[a];
            end
            w_dist[a] = (w_val[a] >= gic_pkg::CENTER) ? (w_val[a] - gic_pkg::CENTER)
                                                      : (gic_pkg::CENTER - w_val[a]);
            if (w_dist[a] < i_cfg.deadzone) begin
                w_val[a] = gic_pkg::CENTER;
            end
            o_axes[a] = i_cfg.analog_enable[a] ? w_val[a] : r_held[i_slot][a];
        end
    end

    // Held values start centered; disabled axes rewrite their old value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DEVICES; d++) begin
                for (int a = 0; a < gic_pkg::AXES; a++) begin
                    r_held[d][a] <= gic_pkg::CENTER;
                end
            end
        end else if (i_update) begin
            for (int a = 0; a < gic_pkg::AXES; a++) begin
                r_held[i_slot][a] <= o_axes[a];
            end
        end
    end

endmodule

FILE: sv/gamepad_input_conditioner_core.sv
// Top level of the gamepad input conditioner: input word register, per-controller
// tables and result word register.
//
//  Channel  | Handshake                | Carries
//  ---------+--------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready  | device index, 18 pin levels, 4 samples
//  result   | o_out_valid / i_out_ready| device, held buttons, 4 conditioned axes
//  config   | i_cfg_valid / o_cfg_ready| register index and write data
//
// A poll is captured in the input register, conditioned there while the
// controller tables update, and shown from the result register: one word per
// cycle while the result is taken. A poll of an unregistered controller leaves
// the input register without a result. Reset clears the tables (axes centered),
// the configuration and the valid flags; a stalled result word holds the pipeline behind it.
module gamepad_input_conditioner_core #(
    parameter int MAX_DEVICES = gic_pkg::MAX_DEVICES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gic_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gic_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Poll channel.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [gic_pkg::DEV_W-1:0]      i_device_index,
    input  logic [gic_pkg::BTN_W-1:0]      i_button_levels,
    input  logic [gic_pkg::SAMPLE_W-1:0]   i_left_x_sample,
    input  logic [gic_pkg::SAMPLE_W-1:0]   i_left_y_sample,
    input  logic [gic_pkg::SAMPLE_W-1:0]   i_right_x_sample,
    input  logic [gic_pkg::SAMPLE_W-1:0]   i_right_y_sample,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [gic_pkg::DEV_W-1:0]      o_result_device,
    output logic [gic_pkg::BTN_W-1:0]      o_pressed_buttons,
    output logic [gic_pkg::AXIS_W-1:0]     o_left_x,
    output logic [gic_pkg::AXIS_W-1:0]     o_left_y,
    output logic [gic_pkg::AXIS_W-1:0]     o_right_x,
    output logic [gic_pkg::AXIS_W-1:0]     o_right_y
);

    localparam int SLOT_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

    gic_pkg::t_cfg               r_cfg;
    logic                        r_in_valid;
    logic [gic_pkg::DEV_W-1:0]   r_in_device;
    gic_pkg::t_buttons           r_in_levels;
    gic_pkg::t_sample            r_in_samples [gic_pkg::AXES];
    logic                        r_out_valid;
    logic [gic_pkg::DEV_W-1:0]   r_out_device;
    gic_pkg::t_buttons           r_out_buttons;
    gic_pkg::t_axis              r_out_axes [gic_pkg::AXES];

    logic                        w_registered;
    logic                        w_advance;
    logic                        w_update;
    logic [SLOT_W-1:0]           w_slot;
    gic_pkg::t_buttons           w_held;
    gic_pkg::t_axis              w_axes [gic_pkg::AXES];

    // Configuration registers accept a word in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gic_pkg::CFG_DEVICE_COUNT: begin
                    r_cfg.device_count <= i_cfg_data[gic_pkg::COUNT_W-1:0];
                end
                gic_pkg::CFG_PRESS_LEVEL: begin
                    r_cfg.press_level <= i_cfg_data[0];
                end
                gic_pkg::CFG_BUTTON_ENABLE: begin
                    r_cfg.button_enable <= i_cfg_data[gic_pkg::BTN_W-1:0];
                end
                gic_pkg::CFG_ANALOG_ENABLE: begin
                    r_cfg.analog_enable <= i_cfg_data[gic_pkg::AXES-1:0];
                end
                gic_pkg::CFG_AXIS_INVERT: begin
                    r_cfg.axis_invert <= i_cfg_data[gic_pkg::AXES-1:0];
                end
                gic_pkg::CFG_DEADZONE: begin
                    r_cfg.deadzone <= i_cfg_data[gic_pkg::AXIS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A poll yields a result only for a registered controller slot.
    assign w_registered = (32'(r_in_device) < MAX_DEVICES) &&
                          ({1'b0, r_in_device} < r_cfg.device_count);
    assign w_advance    = r_in_valid && (!w_registered || !r_out_valid || i_out_ready);
    assign w_update     = w_advance && w_registered;
    assign w_slot       = SLOT_W'(r_in_device);
    assign o_in_ready   = !r_in_valid || w_advance;

    // Input word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_device     <= i_device_index;
            r_in_levels     <= i_button_levels;
            r_in_samples[0] <= i_left_x_sample;
            r_in_samples[1] <= i_left_y_sample;
            r_in_samples[2] <= i_right_x_sample;
            r_in_samples[3] <= i_right_y_sample;
        end
    end

    // Per-controller button and axis tables.
    gic_button_debounce #(
        .MAX_DEVICES (MAX_DEVICES),
        .SLOT_W      (SLOT_W)
    ) u_buttons (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_update (w_update),
        .i_slot   (w_slot),
        .i_levels (r_in_levels),
        .o_held   (w_held)
    );

    gic_axis_hold #(
        .MAX_DEVICES (MAX_DEVICES),
        .SLOT_W      (SLOT_W)
    ) u_axes (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_update  (w_update),
        .i_slot    (w_slot),
        .i_samples (r_in_samples),
        .o_axes    (w_axes)
    );

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out_device  <= r_in_device;
            r_out_buttons <= w_held;
            for (int a = 0; a < gic_pkg::AXES; a++) begin
                r_out_axes[a] <= w_axes[a];
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_device   = r_out_device;
    assign o_pressed_buttons = r_out_buttons;
    assign o_left_x          = r_out_axes[0];
    assign o_left_y          = r_out_axes[1];
    assign o_right_x         = r_out_axes[2];
    assign o_right_y         = r_out_axes[3];

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the gamepad input conditioner core.
`timescale 1ns / 100ps

module testbench;

    // Run control.
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 12;
    localparam int LONG_HOLD        = 120;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int RANDOM_PHASES    = 8;
    localparam int POLLS_PER_PHASE  = 130;
    localparam logic [gic_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
    localparam gic_pkg::t_axis AXIS_FULL = 8'd255;

    typedef enum logic [1:0] {WORD_POLL, WORD_CFG, WORD_SETTLE} t_word_kind;

    // One pending word for the driver: a poll, a register write or a wait for idle.
    typedef struct packed {
        t_word_kind                                        kind;
        logic [gic_pkg::DEV_W-1:0]                         dev;
        gic_pkg::t_buttons                                 levels;
        logic [gic_pkg::AXES-1:0][gic_pkg::SAMPLE_W-1:0]   samples;
        logic [gic_pkg::CFG_IDX_W-1:0]                     cfg_index;
        logic [gic_pkg::CFG_DATA_W-1:0]                    cfg_data;
    } t_word;

    // One expected report word.
    typedef struct packed {
        logic [gic_pkg::DEV_W-1:0]                       dev;
        gic_pkg::t_buttons                               buttons;
        logic [gic_pkg::AXES-1:0][gic_pkg::AXIS_W-1:0]   axes;
    } t_report;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [gic_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [gic_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [gic_pkg::DEV_W-1:0]      i_device_index = '0;
    gic_pkg::t_buttons              i_button_levels = '0;
    gic_pkg::t_sample               i_left_x_sample = '0;
    gic_pkg::t_sample               i_left_y_sample = '0;
    gic_pkg::t_sample               i_right_x_sample = '0;
    gic_pkg::t_sample               i_right_y_sample = '0;

    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [gic_pkg::DEV_W-1:0]      o_result_device;
    gic_pkg::t_buttons              o_pressed_buttons;
    gic_pkg::t_axis                 o_left_x;
    gic_pkg::t_axis                 o_left_y;
    gic_pkg::t_axis                 o_right_x;
    gic_pkg::t_axis                 o_right_y;

    gamepad_input_conditioner_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_device_index    (i_device_index),
        .i_button_levels   (i_button_levels),
        .i_left_x_sample   (i_left_x_sample),
        .i_left_y_sample   (i_left_y_sample),
        .i_right_x_sample  (i_right_x_sample),
        .i_right_y_sample  (i_right_y_sample),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result_device   (o_result_device),
        .o_pressed_buttons (o_pressed_buttons),
        .o_left_x          (o_left_x),
        .o_left_y          (o_left_y),
        .o_right_x         (o_right_x),
        .o_right_y         (o_right_y)
    );

    t_word   pending_words[$];
    t_report expected_reports[$];
    int      mismatches = 0;

    // Predictor copy of the shared registers and the per-controller tables.
    gic_pkg::t_cfg     cfg_copy;
    gic_pkg::t_buttons raw_last [gic_pkg::MAX_DEVICES_DEF];
    gic_pkg::t_buttons held_btn [gic_pkg::MAX_DEVICES_DEF];
    gic_pkg::t_axis    held_axis [gic_pkg::MAX_DEVICES_DEF][gic_pkg::AXES];

    // Stimulus generator memory: the pin levels each controller currently shows.
    gic_pkg::t_buttons stim_levels [gic_pkg::MAX_DEVICES_DEF];
    int       gen_deadzone = 0;
    int       polls_counted = 0;

    // Driver, receiver and watchdog bookkeeping.
    int send_gap = 0;
    int send_quiet = 0;
    int settle_count = 0;
    int take_gap = 0;
    int take_quiet = 0;
    int results_taken = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Wait drawn per word, with occasional stretches of back-to-back words.
    function automatic int pick_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) quiet_left = $urandom_range(8, 40);
        return $urandom_range(0, 10);
    endfunction

    // Top 8 bits of a sample, optional inversion, then the deadzone snap.
    function automatic gic_pkg::t_axis condition_stick(gic_pkg::t_sample s, logic inv);
        gic_pkg::t_axis v;
        gic_pkg::t_axis off;
        v = s[gic_pkg::SAMPLE_W-1:gic_pkg::SAMPLE_W-gic_pkg::AXIS_W];
        if (inv) v = AXIS_FULL - v;
        off = (v >= gic_pkg::CENTER) ? v - gic_pkg::CENTER : gic_pkg::CENTER - v;
        if (off < cfg_copy.deadzone) v = gic_pkg::CENTER;
        return v;
    endfunction

    function automatic void apply_register(logic [gic_pkg::CFG_IDX_W-1:0] idx,
                                           logic [gic_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            gic_pkg::CFG_DEVICE_COUNT:
                cfg_copy.device_count  = data[gic_pkg::COUNT_W-1:0];
            gic_pkg::CFG_PRESS_LEVEL:
                cfg_copy.press_level   = data[0];
            gic_pkg::CFG_BUTTON_ENABLE:
                cfg_copy.button_enable = data[gic_pkg::BTN_W-1:0];
            gic_pkg::CFG_ANALOG_ENABLE:
                cfg_copy.analog_enable = data[gic_pkg::AXES-1:0];
            gic_pkg::CFG_AXIS_INVERT:
                cfg_copy.axis_invert   = data[gic_pkg::AXES-1:0];
            gic_pkg::CFG_DEADZONE:
                cfg_copy.deadzone      = data[gic_pkg::AXIS_W-1:0];
            default: ;
        endcase
    endfunction

    // Updates the tables for one accepted poll; returns 1 when it yields a report.
    function automatic logic predict_report(
            logic [gic_pkg::DEV_W-1:0] dev, gic_pkg::t_buttons levels,
            logic [gic_pkg::AXES-1:0][gic_pkg::SAMPLE_W-1:0] samples,
            output t_report rpt);
        gic_pkg::t_buttons pressed;
        rpt = '0;
        if (dev >= cfg_copy.device_count) return 1'b0;
        pressed = cfg_copy.press_level ? levels : ~levels;
        pressed &= cfg_copy.button_enable;
        if (pressed == raw_last[dev]) held_btn[dev] = pressed;
        raw_last[dev] = pressed;
        for (int a = 0; a < gic_pkg::AXES; a++) begin
            if (cfg_copy.analog_enable[a])
                held_axis[dev][a] = condition_stick(samples[a], cfg_copy.axis_invert[a]);
            rpt.axes[a] = held_axis[dev][a];
        end
        rpt.dev = dev;
        rpt.buttons = held_btn[dev];
        return 1'b1;
    endfunction

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_cfg(logic [gic_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        t_word w;
        w = '0;
        w.kind = WORD_CFG;
        w.cfg_index = idx;
        w.cfg_data = value[gic_pkg::CFG_DATA_W-1:0];
        pending_words.push_back(w);
    endtask

    task automatic add_settle();
        t_word w;
        w = '0;
        w.kind = WORD_SETTLE;
        pending_words.push_back(w);
    endtask

    task automatic add_poll(int dev, gic_pkg::t_buttons levels,
                            gic_pkg::t_sample lx, gic_pkg::t_sample ly,
                            gic_pkg::t_sample rx, gic_pkg::t_sample ry);
        t_word w;
        w = '0;
        w.kind = WORD_POLL;
        w.dev = dev[gic_pkg::DEV_W-1:0];
        w.levels = levels;
        w.samples = {ry, rx, ly, lx};
        pending_words.push_back(w);
    endtask

    // Samples: full random, rail values, or values hugging the deadzone edge.
    function automatic gic_pkg::t_sample pick_sample();
        int v;
        logic [3:0] low_bits;
        low_bits = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0: return gic_pkg::t_sample'($urandom_range(0, 4095));
            1: return $urandom_range(0, 1) ? '1 : '0;
            2: begin
                v = 128 + $urandom_range(0, 2 * gen_deadzone + 2) - (gen_deadzone + 1);
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return {v[7:0], low_bits};
            end
            default: return {gic_pkg::t_axis'($urandom_range(0, 255)), low_bits};
        endcase
    endfunction

    // Mostly repeated pin levels so the debounce accepts them, with some changes.
    task automatic add_random_poll(int live);
        int dev;
        int pick;
        if ($urandom_range(0, 6) != 0) dev = $urandom_range(0, live - 1);
        else dev = $urandom_range(0, 3);
        pick = $urandom_range(0, 9);
        if (pick == 6 || pick == 7)
            stim_levels[dev] ^= gic_pkg::t_buttons'(1) << $urandom_range(0, gic_pkg::BTN_W - 1);
        else if (pick == 8)
            stim_levels[dev] = gic_pkg::t_buttons'($urandom());
        else if (pick == 9)
            stim_levels[dev] = $urandom_range(0, 1) ? '1 : '0;
        add_poll(dev, stim_levels[dev], pick_sample(), pick_sample(), pick_sample(),
                 pick_sample());
        if (dev < live) polls_counted++;
    endtask

    // Driver: presents pending words one at a time, holding each until accepted.
    always @(posedge i_clk) begin : driver
        logic next_in;
        logic next_cfg;
        t_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            next_in = i_in_valid && !o_in_ready;
            next_cfg = i_cfg_valid && !o_cfg_ready;
            if (!next_in && !next_cfg) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_words.size() != 0) begin
                    w = pending_words[0];
                    case (w.kind)
                        WORD_POLL: begin
                            void'(pending_words.pop_front());
                            i_device_index <= w.dev;
                            i_button_levels <= w.levels;
                            i_left_x_sample <= w.samples[0];
                            i_left_y_sample <= w.samples[1];
                            i_right_x_sample <= w.samples[2];
                            i_right_y_sample <= w.samples[3];
                            next_in = 1'b1;
                            send_gap = pick_wait(send_quiet);
                        end
                        WORD_CFG: begin
                            void'(pending_words.pop_front());
                            i_cfg_index <= w.cfg_index;
                            i_cfg_data <= w.cfg_data;
                            next_cfg = 1'b1;
                            send_gap = pick_wait(send_quiet);
                        end
                        default: begin
                            // Idle only once every report is in and the pipeline has drained.
                            if (expected_reports.size() == 0) settle_count++;
                            else settle_count = 0;
                            if (settle_count >= SETTLE_CYCLES) begin
                                void'(pending_words.pop_front());
                                settle_count = 0;
                            end
                        end
                    endcase
                end
            end
            i_in_valid <= next_in;
            i_cfg_valid <= next_cfg;
        end
    end

    // Receiver: random stalls per report word, plus long hold-offs that back up the input.
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            results_taken++;
            take_gap = pick_wait(take_quiet);
            if (results_taken % 400 == 150) take_gap = LONG_HOLD;
            i_out_ready <= (take_gap == 0);
        end else if (!i_out_ready) begin
            if (take_gap > 0) take_gap--;
            i_out_ready <= (take_gap == 0);
        end
    end

    // Monitor: tracks register writes and polls, checks each report word.
    always @(posedge i_clk) begin : monitor
        t_report want;
        t_report rpt;
        if (!i_rst_n) begin
            cfg_copy = '0;
            for (int d = 0; d < gic_pkg::MAX_DEVICES_DEF; d++) begin
                raw_last[d] = '0;
                held_btn[d] = '0;
                for (int a = 0; a < gic_pkg::AXES; a++) held_axis[d][a] = gic_pkg::CENTER;
            end
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: report word for device %0d with none expected",
                             $time, o_result_device);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    compare_field("result_device", want.dev, o_result_device);
                    compare_field("pressed_buttons", want.buttons, o_pressed_buttons);
                    compare_field("left_x", want.axes[0], o_left_x);
                    compare_field("left_y", want.axes[1], o_left_y);
                    compare_field("right_x", want.axes[2], o_right_x);
                    compare_field("right_y", want.axes[3], o_right_y);
                end
            end
            if (i_cfg_valid && o_cfg_ready) apply_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                if (predict_report(i_device_index, i_button_levels,
                                   {i_right_y_sample, i_right_x_sample,
                                    i_left_y_sample, i_left_x_sample}, rpt))
                    expected_reports.push_back(rpt);
            end
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready) ||
                     (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus: directed corner cases, then randomized register phases.
    initial begin : stimulus
        int dc;
        int live;
        int unsigned enable_bits;
        for (int d = 0; d < gic_pkg::MAX_DEVICES_DEF; d++) stim_levels[d] = '1;

        // No controllers registered yet, so this poll must be dropped.
        add_poll(0, '1, 12'h000, 12'hFFF, 12'h800, 12'h7FF);
        add_settle();
        add_cfg(gic_pkg::CFG_DEVICE_COUNT, 4);
        add_cfg(gic_pkg::CFG_PRESS_LEVEL, 0);
        add_cfg(gic_pkg::CFG_BUTTON_ENABLE, 18'h3FFFF);
        add_cfg(gic_pkg::CFG_ANALOG_ENABLE, 4'hF);
        add_cfg(gic_pkg::CFG_AXIS_INVERT, 4'h0);
        add_cfg(gic_pkg::CFG_DEADZONE, 0);

        // Debounce: a new pressed word only sticks on its second read.
        add_poll(0, '1, 12'h000, 12'hFFF, 12'h800, 12'h7FF);
        add_poll(0, '0, 12'h7F0, 12'h810, 12'h00F, 12'hFF0);
        add_poll(0, '0, 12'h7F0, 12'h810, 12'h00F, 12'hFF0);
        add_poll(1, 18'h2AAAA, 12'h000, 12'hFFF, 12'h800, 12'h7FF);
        add_poll(1, 18'h2AAAA, 12'hFFF, 12'h000, 12'h7FF, 12'h800);
        add_poll(1, 18'h15555, 12'h123, 12'h456, 12'h789, 12'hABC);
        add_poll(3, '0, 12'hFFF, 12'hFFF, 12'h000, 12'h000);
        add_poll(2, '1, 12'h800, 12'h800, 12'h800, 12'h800);

        // Active-high pins, inverted axes, widest deadzone, two axes frozen.
        add_settle();
        add_cfg(gic_pkg::CFG_PRESS_LEVEL, 1);
        add_cfg(gic_pkg::CFG_AXIS_INVERT, 4'hF);
        add_cfg(gic_pkg::CFG_DEADZONE, 255);
        add_cfg(gic_pkg::CFG_ANALOG_ENABLE, 4'h5);
        add_poll(0, '1, 12'h000, 12'hFFF, 12'hFFF, 12'h000);
        add_poll(0, '1, 12'hFFF, 12'h000, 12'h000, 12'hFFF);

        // Values right at the deadzone edge.
        add_settle();
        add_cfg(gic_pkg::CFG_DEADZONE, 2);
        add_cfg(gic_pkg::CFG_ANALOG_ENABLE, 4'hF);
        add_cfg(gic_pkg::CFG_AXIS_INVERT, 4'hA);
        add_poll(2, 18'h00001, 12'h7F0, 12'h810, 12'h7E0, 12'h800);
        add_settle();
        add_cfg(gic_pkg::CFG_DEADZONE, 1);
        add_poll(2, 18'h20000, 12'h7F0, 12'h810, 12'h80F, 12'h7FF);

        // Fewer controllers hide the upper ones; raising the count again resumes them.
        add_settle();
        add_cfg(gic_pkg::CFG_DEVICE_COUNT, 2);
        add_poll(3, 18'h0F0F0, 12'h111, 12'h222, 12'h333, 12'h444);
        add_poll(2, 18'h0F0F0, 12'h111, 12'h222, 12'h333, 12'h444);
        add_poll(1, 18'h0F0F0, 12'h111, 12'h222, 12'h333, 12'h444);
        add_settle();
        add_cfg(gic_pkg::CFG_DEVICE_COUNT, 7);
        add_poll(3, 18'h3C3C3, 12'hEEE, 12'hDDD, 12'hCCC, 12'hBBB);
        add_poll(2, 18'h3C3C3, 12'hEEE, 12'hDDD, 12'hCCC, 12'hBBB);

        // Partly wired buttons, all axes holding.
        add_settle();
        add_cfg(gic_pkg::CFG_BUTTON_ENABLE, 18'h0F0F3);
        add_cfg(gic_pkg::CFG_ANALOG_ENABLE, 4'h0);
        add_poll(0, 18'h2D2D2, 12'h000, 12'h000, 12'h000, 12'h000);
        add_poll(0, 18'h2D2D2, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);

        // A write to an unused register index must change nothing.
        add_settle();
        add_cfg(CFG_UNUSED, 18'h3FFFF);
        add_poll(0, 18'h2D2D2, 12'h000, 12'hFFF, 12'h000, 12'hFFF);

        // Random phases, each with its own register setting.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0, 3, 6: dc = 4;
                1:       dc = 7;
                2:       dc = 3;
                4:       dc = 1;
                5:       dc = 5;
                default: dc = $urandom_range(1, 7);
            endcase
            if (p == 2) enable_bits = 0;
            else if (p % 2 == 0) enable_bits = 18'h3FFFF;
            else enable_bits = $urandom_range(0, 18'h3FFFF);
            if (p == 0) gen_deadzone = 0;
            else if (p == 1) gen_deadzone = 255;
            else if (p % 2 == 1) gen_deadzone = $urandom_range(0, 255);
            else gen_deadzone = $urandom_range(1, 40);
            add_settle();
            add_cfg(gic_pkg::CFG_DEVICE_COUNT, dc);
            add_cfg(gic_pkg::CFG_PRESS_LEVEL, p % 2);
            add_cfg(gic_pkg::CFG_BUTTON_ENABLE, enable_bits);
            add_cfg(gic_pkg::CFG_ANALOG_ENABLE,
                    (p == 4) ? 0 : ((p % 2 == 1) ? $urandom_range(0, 15) : 15));
            add_cfg(gic_pkg::CFG_AXIS_INVERT, (p == 3) ? 15 : $urandom_range(0, 15));
            add_cfg(gic_pkg::CFG_DEADZONE, gen_deadzone);
            live = (dc > gic_pkg::MAX_DEVICES_DEF) ? gic_pkg::MAX_DEVICES_DEF : dc;
            polls_counted = 0;
            while (polls_counted < POLLS_PER_PHASE) add_random_poll(live);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to be sent and every report to come back.
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || i_cfg_valid ||
               expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/gic_pkg.sv
sv/gic_button_debounce.sv
sv/gic_axis_hold.sv
sv/gamepad_input_conditioner_core.sv
verif/testbench.sv
